[rtl/core/pts_pkg.sv]
// package: types and constants for the periodic timer scheduler
package pts_pkg;
   localparam int SLOTS = 16;
   localparam int SLOT_W = 4;
   localparam int TIME_W = 48;
   localparam int IVAL_W = 32;

   typedef enum logic [1:0] {
      CMD_REG   = 2'd0,
      CMD_UNREG = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_IVL = 2'd1,
      ST_ALREADY  = 2'd2,
      ST_NOT_REG  = 2'd3
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // capture request word
      logic scan_clr;    // restart slot scan
      logic scan_step;   // examine one slot (min search or collision check)
      logic mode_min;    // 1: search min expired, 0: collision check
      logic take_min;    // mark best slot fired, push to order list
      logic cand_set_reg;   // candidate = now + delay
      logic cand_set_ivl;   // candidate = now + interval of order[idx]
      logic cand_bump;   // candidate + 1
      logic arm_reg;     // arm request slot with candidate
      logic arm_ord;     // arm order[idx] slot with candidate
      logic unreg;       // clear request slot
      logic idx_clr;
      logic idx_inc;
   } ctl_type;

   typedef struct packed {
      cmd_type     cmd;
      logic        ivl_zero;
      logic        slot_armed;
      logic        scan_done;  // last slot examined this cycle
      logic        found;      // min search found a slot / candidate taken
      logic [SLOT_W:0] count;  // fired count
      logic        idx_last;   // idx == count-1
   } sts_type;
endpackage

[rtl/core/periodic_timer_scheduler.sv]
// top level: periodic timer scheduler
//
//  channel | ports                                          | dir
//  req     | req_valid req_stall req_cmd/slot/interval/delay/now | in
//  rsp     | rsp_valid rsp_stall rsp_kind/status/fired_slot/fire_time/last | out
//
// one word at a time: req_stall is high until the controller returns to idle; unregister
// only updates the slot, register runs a collision scan rescanned per expiry bump, a tick
// runs a min search per fired slot, emits the fired words, then a collision scan per
// fired slot with the same bump; the single slot scan port examines one slot per cycle
// synchronous active-high reset clears all slot valid bits and control
// a stalled rsp word holds; the controller waits for the output register
module periodic_timer_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_interval,
   input  logic [31:0] req_delay,
   input  logic [47:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_fired_slot,
   output logic [47:0] rsp_fire_time,
   output logic        rsp_last
);
   import pts_pkg::*;

   ctl_type    ctl;
   sts_type    sts;
   logic       out_load, out_kind, out_last, out_busy;
   status_type out_status;
   logic [SLOT_W-1:0] fslot;
   logic [TIME_W-1:0] now_q;

   logic        vld_ff;
   logic        kind_ff, last_ff;
   logic [1:0]  stat_ff;
   logic [3:0]  slot_ff;
   logic [47:0] time_ff;

   // output register frees when taken
   assign out_busy = vld_ff && rsp_stall;

   pts_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .sts, .ctl,
      .out_load, .out_kind, .out_status, .out_last, .out_busy
   );

   pts_datapath u_dp (
      .clock, .reset, .ctl, .sts, .req_cmd, .req_slot, .req_interval,
      .req_delay, .req_now, .fired_slot(fslot), .now_q
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (out_load) vld_ff <= 1'b1;
      else if (!rsp_stall) vld_ff <= 1'b0;
      if (out_load) begin
         kind_ff <= out_kind;
         stat_ff <= out_status;
         last_ff <= out_last;
         // status words carry zero slot and time
         slot_ff <= out_kind ? fslot : '0;
         time_ff <= out_kind ? now_q : '0;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_kind = kind_ff;
   assign rsp_status = stat_ff;
   assign rsp_fired_slot = slot_ff;
   assign rsp_fire_time = time_ff;
   assign rsp_last = last_ff;
endmodule

[rtl/core/pts_datapath.sv]
// datapath: slot table, candidate time, slot scan and fired list
module pts_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  pts_pkg::ctl_type       ctl,
   output pts_pkg::sts_type       sts,
   input  logic [1:0]             req_cmd,
   input  logic [3:0]             req_slot,
   input  logic [31:0]            req_interval,
   input  logic [31:0]            req_delay,
   input  logic [47:0]            req_now,
   output logic [pts_pkg::SLOT_W-1:0] fired_slot,
   output logic [pts_pkg::TIME_W-1:0] now_q
);
   import pts_pkg::*;

   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [IVAL_W-1:0] ivl_mem [SLOTS];
   logic [TIME_W-1:0] exp_mem [SLOTS];
   logic [1:0]        cmd_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [IVAL_W-1:0] ivl_ff, dly_ff;
   logic [TIME_W-1:0] now_ff, cand_ff;
   logic [SLOT_W-1:0] scan_ff;
   logic [SLOT_W-1:0] best_ff;
   logic [TIME_W-1:0] best_exp_ff;
   logic              found_ff;
   logic [SLOT_W-1:0] order_ff [SLOTS];
   logic [SLOT_W:0]   count_ff, idx_ff;
   logic [SLOT_W-1:0] cur_ord;
   logic              hit;

   assign cur_ord = order_ff[idx_ff[SLOT_W-1:0]];
   assign hit = ctl.mode_min ?
      (valid_ff[scan_ff] && exp_mem[scan_ff] <= now_ff &&
       (!found_ff || exp_mem[scan_ff] < best_exp_ff)) :
      (valid_ff[scan_ff] && exp_mem[scan_ff] == cand_ff);

   always_comb begin
      valid_in = valid_ff;
      if (ctl.take_min) valid_in[best_ff] = 1'b0;
      if (ctl.arm_reg) valid_in[slot_ff] = 1'b1;
      if (ctl.arm_ord) valid_in[cur_ord] = 1'b1;
      if (ctl.unreg) valid_in[slot_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         idx_ff <= '0;
         found_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.scan_clr) begin
            scan_ff <= '0;
            found_ff <= 1'b0;
         end else if (ctl.scan_step) begin
            scan_ff <= scan_ff + 1'b1;
            if (hit) begin
               found_ff <= 1'b1;
               best_ff <= scan_ff;
               best_exp_ff <= exp_mem[scan_ff];
            end
         end
         if (ctl.load) count_ff <= '0;
         else if (ctl.take_min) begin
            order_ff[count_ff[SLOT_W-1:0]] <= best_ff;
            count_ff <= count_ff + 1'b1;
         end
         if (ctl.idx_clr) idx_ff <= '0;
         else if (ctl.idx_inc) idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_cmd;
         slot_ff <= req_slot;
         ivl_ff <= req_interval;
         dly_ff <= req_delay;
         now_ff <= req_now;
      end
      if (ctl.cand_set_reg) cand_ff <= now_ff + {16'd0, dly_ff};
      else if (ctl.cand_set_ivl) cand_ff <= now_ff + {16'd0, ivl_mem[cur_ord]};
      else if (ctl.cand_bump) cand_ff <= cand_ff + 1'b1;
      if (ctl.arm_reg) begin
         exp_mem[slot_ff] <= cand_ff;
         ivl_mem[slot_ff] <= ivl_ff;
      end
      if (ctl.arm_ord) exp_mem[cur_ord] <= cand_ff;
   end

   always_comb begin
      sts.cmd = cmd_type'(cmd_ff);
      sts.ivl_zero = (ivl_ff == '0);
      sts.slot_armed = valid_ff[slot_ff];
      sts.scan_done = (scan_ff == SLOT_W'(SLOTS - 1));
      sts.found = found_ff;
      sts.count = count_ff;
      sts.idx_last = (idx_ff + 1'b1 == count_ff);
   end
   assign fired_slot = cur_ord;
   assign now_q = now_ff;
endmodule

[rtl/core/pts_ctrl.sv]
// controller: sequences register, unregister and tick commands
module pts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pts_pkg::sts_type    sts,
   output pts_pkg::ctl_type    ctl,
   output logic                out_load,
   output logic                out_kind,
   output pts_pkg::status_type out_status,
   output logic                out_last,
   input  logic                out_busy
);
   import pts_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DEC   = 10'b0000000010,
      S_MIN   = 10'b0000000100,
      S_TAKE  = 10'b0000001000,
      S_EMIT  = 10'b0000010000,
      S_IVL   = 10'b0000100000,
      S_CHK   = 10'b0001000000,
      S_ARM   = 10'b0010000000,
      S_RCHK  = 10'b0100000000,
      S_STAT  = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   status_type st_ff, st_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      st_in = st_ff;
      ctl = '0;
      out_load = 1'b0;
      out_kind = 1'b0;
      out_status = st_ff;
      out_last = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            ctl.scan_clr = 1'b1;
            ctl.cand_set_reg = 1'b1;
            ctl.idx_clr = 1'b1;
            case (sts.cmd)
               CMD_REG: begin
                  if (sts.ivl_zero) begin
                     st_in = ST_ZERO_IVL; state_in = S_STAT;
                  end else if (sts.slot_armed) begin
                     st_in = ST_ALREADY; state_in = S_STAT;
                  end else begin
                     st_in = ST_OK; state_in = S_RCHK;
                  end
               end
               CMD_UNREG: begin
                  st_in = sts.slot_armed ? ST_OK : ST_NOT_REG;
                  ctl.unreg = sts.slot_armed;
                  state_in = S_STAT;
               end
               CMD_TICK: begin
                  ctl.mode_min = 1'b1;
                  state_in = S_MIN;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RCHK: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_ARM;
         end
         S_MIN: begin
            ctl.mode_min = 1'b1;
            ctl.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_TAKE;
         end
         S_TAKE: begin
            if (sts.found) begin
               ctl.take_min = 1'b1;
               ctl.scan_clr = 1'b1;
               state_in = S_MIN;
            end else if (sts.count == '0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_busy) begin
               out_load = 1'b1;
               out_kind = 1'b1;
               out_status = ST_OK;
               out_last = sts.idx_last;
               ctl.idx_inc = 1'b1;
               if (sts.idx_last) begin
                  ctl.idx_clr = 1'b1;
                  ctl.idx_inc = 1'b0;
                  state_in = S_IVL;
               end
            end
         end
         S_IVL: begin
            ctl.cand_set_ivl = 1'b1;
            ctl.scan_clr = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_ARM;
         end
         S_ARM: begin
            // candidate taken: bump and rescan, else arm
            if (sts.found) begin
               ctl.cand_bump = 1'b1;
               ctl.scan_clr = 1'b1;
               state_in = (sts.cmd == CMD_TICK) ? S_CHK : S_RCHK;
            end else if (sts.cmd == CMD_TICK) begin
               ctl.arm_ord = 1'b1;
               if (sts.idx_last) state_in = S_IDLE;
               else begin
                  ctl.idx_inc = 1'b1;
                  state_in = S_IVL;
               end
            end else begin
               ctl.arm_reg = 1'b1;
               state_in = S_STAT;
            end
         end
         S_STAT: begin
            if (!out_busy) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff <= ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff <= st_in;
      end
   end
endmodule
